// ===== hdl/dmq_pkg.sv =====
// Shared types and constants for the deduplicating message queue.
// Used by every module of the block but dmq_ram; depends on nothing.
`default_nettype none

package dmq_pkg;

  // Fixed field widths of the item interface.
  localparam int FuncW     = 2;
  localparam int MsgIdW    = 9;
  localparam int HoldW     = 16;
  localparam int TickW     = 32;
  localparam int PlayIdW   = 8;
  localparam int StatusW   = 3;
  localparam int CountW    = 4;
  localparam int LimitW    = 4;

  localparam logic [LimitW-1:0] QueueLimitReset = 4'd4;

  // Operation codes carried by the func field.
  typedef enum logic [FuncW-1:0] {
    FN_POST    = 2'd0,
    FN_SERVICE = 2'd1,
    FN_CLEAR   = 2'd2
  } func_e;

  // Result status codes.
  typedef enum logic [StatusW-1:0] {
    STAT_STARTED = 3'd0,
    STAT_QUEUED  = 3'd1,
    STAT_CURRENT = 3'd2,
    STAT_INVALID = 3'd3,
    STAT_HELD    = 3'd4,
    STAT_FULL    = 3'd5,
    STAT_DUP     = 3'd6,
    STAT_NONE    = 3'd7
  } status_e;

  // Control sequencer states.
  typedef enum logic {
    S_IDLE   = 1'b0,
    S_DECIDE = 1'b1
  } ctrl_state_e;

  // One accepted input item.
  typedef struct packed {
    logic [FuncW-1:0]  func;
    logic [MsgIdW-1:0] msg_id;
    logic [HoldW-1:0]  hold_ticks;
    logic [TickW-1:0]  now_tick;
    logic              player_busy;
  } item_t;

  // Write of one hold-off entry.
  typedef struct packed {
    logic              en;
    logic [MsgIdW-1:0] id;
    logic [TickW-1:0]  expiry;
  } hold_wr_t;

  // Hold-off lookup result.
  typedef struct packed {
    logic             valid;
    logic [TickW-1:0] expiry;
  } hold_rd_t;

  // Queue update for one item.
  typedef struct packed {
    logic              push;
    logic              pop;
    logic              clear;
    logic [MsgIdW-1:0] id;
    logic [HoldW-1:0]  hold;
  } queue_op_t;

  // Queue state seen by the decision logic.
  typedef struct packed {
    logic [CountW-1:0] fill;
    logic [MsgIdW-1:0] head_id;
    logic [HoldW-1:0]  head_hold;
    logic              id_queued;
  } queue_stat_t;

  // Expiry time: now plus hold, saturating at the top of the tick range.
  function automatic logic [TickW-1:0] sat_add(input logic [TickW-1:0] now,
                                               input logic [HoldW-1:0] hold);
    logic [TickW:0] sum;
    sum = {1'b0, now} + {{(TickW + 1 - HoldW){1'b0}}, hold};
    return sum[TickW] ? {TickW{1'b1}} : sum[TickW-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/dmq_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// Stand-alone; used for the hold-off expiry table and the message queue.
`default_nettype none

module dmq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/dmq_holdoff.sv =====
// Hold-off table: one expiry per message id in a RAM, plus a valid flag per id.
// Depends on dmq_pkg and dmq_ram.
`default_nettype none

module dmq_holdoff #(
  parameter int MESSAGE_COUNT = 256
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      rd_en_i,
  input  logic [dmq_pkg::MsgIdW-1:0] rd_id_i,
  input  logic                      clear_i,
  input  dmq_pkg::hold_wr_t         wr_i,
  output dmq_pkg::hold_rd_t         rd_o
);

  import dmq_pkg::*;

  localparam int AddrW = $clog2(MESSAGE_COUNT);

  logic [MESSAGE_COUNT-1:0] valid_q;
  logic                     valid_rd_q;
  logic [AddrW-1:0]         rd_addr;
  logic [AddrW-1:0]         wr_addr;
  logic [TickW-1:0]         expiry_rd;

  assign rd_addr = rd_id_i[AddrW-1:0];
  assign wr_addr = wr_i.id[AddrW-1:0];

  // Valid flags: cleared together by reset or a clear item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (clear_i) begin
      valid_q <= '0;
    end else if (wr_i.en) begin
      valid_q[wr_addr] <= 1'b1;
    end
  end

  // The flag is read alongside the RAM so both arrive in the same cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_rd_q <= 1'b0;
    end else if (rd_en_i) begin
      valid_rd_q <= valid_q[rd_addr];
    end
  end

  dmq_ram #(
    .WIDTH (TickW),
    .DEPTH (MESSAGE_COUNT)
  ) u_expiry_ram (
    .clk_i   (clk_i),
    .we_i    (wr_i.en),
    .waddr_i (wr_addr),
    .wdata_i (wr_i.expiry),
    .re_i    (rd_en_i),
    .raddr_i (rd_addr),
    .rdata_o (expiry_rd)
  );

  assign rd_o.valid  = valid_rd_q;
  assign rd_o.expiry = expiry_rd;

endmodule

`default_nettype wire

// ===== hdl/dmq_queue.sv =====
// Message ring buffer: ids and hold times in a RAM, head and fill in registers,
// and a queued flag per id for duplicate detection. Depends on dmq_pkg, dmq_ram.
`default_nettype none

module dmq_queue #(
  parameter int QUEUE_DEPTH   = 8,
  parameter int MESSAGE_COUNT = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       rd_en_i,
  input  logic [dmq_pkg::MsgIdW-1:0] lookup_id_i,
  input  dmq_pkg::queue_op_t         op_i,
  output dmq_pkg::queue_stat_t       stat_o
);

  import dmq_pkg::*;

  localparam int PtrW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int SumW  = ((PtrW > CountW) ? PtrW : CountW) + 1;
  localparam int IdxW  = $clog2(MESSAGE_COUNT);
  localparam int EntW  = MsgIdW + HoldW;
  localparam logic [PtrW-1:0] LastPtr   = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [SumW-1:0] DepthSum  = SumW'(QUEUE_DEPTH);

  logic [PtrW-1:0]          head_q, head_d;
  logic [CountW-1:0]        fill_q, fill_d;
  logic [MESSAGE_COUNT-1:0] queued_q;
  logic                     queued_rd_q;
  logic [SumW-1:0]          tail_sum;
  logic [PtrW-1:0]          tail;
  logic [EntW-1:0]          head_entry;
  logic [MsgIdW-1:0]        head_id;

  // Tail slot: head plus fill, wrapped once at the queue depth.
  always_comb begin
    tail_sum = SumW'(head_q) + SumW'(fill_q);
    if (tail_sum >= DepthSum) begin
      tail_sum = tail_sum - DepthSum;
    end
    tail = tail_sum[PtrW-1:0];
  end

  // Next head and fill.
  always_comb begin
    head_d = head_q;
    fill_d = fill_q;
    if (op_i.clear) begin
      head_d = '0;
      fill_d = '0;
    end else if (op_i.push) begin
      fill_d = fill_q + CountW'(1);
    end else if (op_i.pop) begin
      head_d = (head_q == LastPtr) ? '0 : head_q + PtrW'(1);
      fill_d = fill_q - CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      fill_q <= '0;
    end else begin
      head_q <= head_d;
      fill_q <= fill_d;
    end
  end

  // One flag per id that is waiting in the queue.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      queued_q <= '0;
    end else if (op_i.clear) begin
      queued_q <= '0;
    end else if (op_i.push) begin
      queued_q[op_i.id[IdxW-1:0]] <= 1'b1;
    end else if (op_i.pop) begin
      queued_q[head_id[IdxW-1:0]] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      queued_rd_q <= 1'b0;
    end else if (rd_en_i) begin
      queued_rd_q <= queued_q[lookup_id_i[IdxW-1:0]];
    end
  end

  dmq_ram #(
    .WIDTH (EntW),
    .DEPTH (QUEUE_DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (op_i.push),
    .waddr_i (tail),
    .wdata_i ({op_i.id, op_i.hold}),
    .re_i    (rd_en_i),
    .raddr_i (head_q),
    .rdata_o (head_entry)
  );

  assign head_id = head_entry[EntW-1:HoldW];

  assign stat_o.fill      = fill_q;
  assign stat_o.head_id   = head_id;
  assign stat_o.head_hold = head_entry[HoldW-1:0];
  assign stat_o.id_queued = queued_rd_q;

endmodule

`default_nettype wire

// ===== hdl/dedup_message_queue_with_holdoff_unit.sv =====
// The hold-off and queue RAM reads are issued on the accepting edge, and the
// decision and write-back land on the commit edge of the decide state.
// No new item is taken before the last one commits, set by the read-then-update
// of the RAMs; a waiting result stalls only the decide cycle of the next item.
// Reset clears the queue, the current message, all hold-off flags and sets
// queue_limit to 4; no clearing pass is needed.
`default_nettype none

module dedup_message_queue_with_holdoff_unit #(
  parameter int QUEUE_DEPTH   = 8,
  parameter int MESSAGE_COUNT = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [dmq_pkg::FuncW-1:0]   func_i,
  input  logic [dmq_pkg::MsgIdW-1:0]  msg_id_i,
  input  logic [dmq_pkg::HoldW-1:0]   hold_ticks_i,
  input  logic [dmq_pkg::TickW-1:0]   now_tick_i,
  input  logic                        player_busy_i,
  input  logic                        cfg_we_i,
  input  logic [dmq_pkg::LimitW-1:0]  cfg_wdata_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        accepted_o,
  output logic                        start_play_o,
  output logic [dmq_pkg::PlayIdW-1:0] play_id_o,
  output logic [dmq_pkg::StatusW-1:0] status_o,
  output logic [dmq_pkg::CountW-1:0]  queue_count_o
);

  import dmq_pkg::*;

  localparam logic [MsgIdW:0] MsgCount = (MsgIdW + 1)'(MESSAGE_COUNT);
  localparam logic [7:0]      DepthCmp = 8'(QUEUE_DEPTH);

  ctrl_state_e       state_q, state_d;
  logic              in_accept;
  logic              commit;
  item_t             item_q;
  logic [LimitW-1:0] limit_q;
  logic              cur_valid_q;
  logic [MsgIdW-1:0] cur_id_q;

  hold_rd_t          hold_rd;
  hold_wr_t          hold_wr, hold_wr_c;
  logic              hold_clr;
  queue_op_t         qop, qop_c;
  queue_stat_t       qstat;

  logic              id_ok, held, full;
  logic              acc_c, start_c, cur_set, cur_clr;
  logic [MsgIdW-1:0] cur_id_c;
  logic [PlayIdW-1:0] pid_c;
  status_e           stat_c;
  logic [CountW-1:0] count_c;

  logic               out_valid_q;
  logic               acc_q, start_q;
  logic [PlayIdW-1:0] pid_q;
  status_e            stat_q;
  logic [CountW-1:0]  count_q;

  // Sequencer: next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_accept) state_d = S_DECIDE;
      S_DECIDE: if (commit) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    in_stall_o = 1'b1;
    commit     = 1'b0;
    case (state_q)
      S_IDLE:   in_stall_o = 1'b0;
      S_DECIDE: commit = !(out_valid_q && out_stall_i);
      default:  in_stall_o = 1'b1;
    endcase
  end

  assign in_accept = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Item register, loaded as the RAM reads are issued.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= '{func: func_i, msg_id: msg_id_i, hold_ticks: hold_ticks_i,
                  now_tick: now_tick_i, player_busy: player_busy_i};
    end
  end

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= QueueLimitReset;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  dmq_holdoff #(
    .MESSAGE_COUNT (MESSAGE_COUNT)
  ) u_holdoff (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_en_i (in_accept),
    .rd_id_i (msg_id_i),
    .clear_i (hold_clr && commit),
    .wr_i    (hold_wr_c),
    .rd_o    (hold_rd)
  );

  dmq_queue #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .MESSAGE_COUNT (MESSAGE_COUNT)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (in_accept),
    .lookup_id_i (msg_id_i),
    .op_i        (qop_c),
    .stat_o      (qstat)
  );

  // Checks shared by the post path. The limit is the smaller of the register
  // and the queue depth.
  assign id_ok = {1'b0, item_q.msg_id} < MsgCount;
  assign held  = hold_rd.valid && (hold_rd.expiry >= item_q.now_tick);
  assign full  = ({4'b0, qstat.fill} >= DepthCmp) || (qstat.fill >= limit_q);

  // Decision for the item in the decide cycle.
  always_comb begin
    acc_c    = 1'b0;
    start_c  = 1'b0;
    pid_c    = '0;
    stat_c   = STAT_NONE;
    hold_wr  = '0;
    hold_clr = 1'b0;
    qop      = '0;
    cur_set  = 1'b0;
    cur_clr  = 1'b0;
    cur_id_c = item_q.msg_id;
    case (func_e'(item_q.func))
      FN_POST: begin
        if (!id_ok) begin
          stat_c = STAT_INVALID;
        end else if (held) begin
          stat_c = STAT_HELD;
        end else if (!item_q.player_busy) begin
          hold_wr = '{en: 1'b1, id: item_q.msg_id,
                      expiry: sat_add(item_q.now_tick, item_q.hold_ticks)};
          cur_set = 1'b1;
          acc_c   = 1'b1;
          start_c = 1'b1;
          pid_c   = item_q.msg_id[PlayIdW-1:0];
          stat_c  = STAT_STARTED;
        end else if (full) begin
          stat_c = STAT_FULL;
        end else if (cur_valid_q && (cur_id_q == item_q.msg_id)) begin
          acc_c  = 1'b1;
          stat_c = STAT_CURRENT;
        end else if (qstat.id_queued) begin
          stat_c = STAT_DUP;
        end else begin
          qop.push = 1'b1;
          qop.id   = item_q.msg_id;
          qop.hold = item_q.hold_ticks;
          acc_c    = 1'b1;
          stat_c   = STAT_QUEUED;
        end
      end
      FN_SERVICE: begin
        if (!item_q.player_busy) begin
          if (qstat.fill == '0) begin
            cur_clr = 1'b1;
          end else begin
            qop.pop  = 1'b1;
            start_c  = 1'b1;
            pid_c    = qstat.head_id[PlayIdW-1:0];
            stat_c   = STAT_STARTED;
            cur_id_c = qstat.head_id;
            // Queued ids were range checked when posted.
            if ({1'b0, qstat.head_id} < MsgCount) begin
              hold_wr = '{en: 1'b1, id: qstat.head_id,
                          expiry: sat_add(item_q.now_tick, qstat.head_hold)};
              cur_set = 1'b1;
            end
          end
        end
      end
      FN_CLEAR: begin
        qop.clear = 1'b1;
        hold_clr  = 1'b1;
        cur_clr   = 1'b1;
      end
      default: begin
        stat_c = STAT_NONE;
      end
    endcase
  end

  // Updates only take effect on the commit edge.
  assign hold_wr_c = commit ? hold_wr : '0;
  assign qop_c     = commit ? qop : '0;

  // Waiting count after this item.
  always_comb begin
    count_c = qstat.fill;
    if (qop.clear) begin
      count_c = '0;
    end else if (qop.push) begin
      count_c = qstat.fill + CountW'(1);
    end else if (qop.pop) begin
      count_c = qstat.fill - CountW'(1);
    end
  end

  // Current message.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      cur_id_q    <= '0;
    end else if (commit) begin
      if (cur_set) begin
        cur_valid_q <= 1'b1;
        cur_id_q    <= cur_id_c;
      end else if (cur_clr) begin
        cur_valid_q <= 1'b0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      acc_q   <= acc_c;
      start_q <= start_c;
      pid_q   <= pid_c;
      stat_q  <= stat_c;
      count_q <= count_c;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign accepted_o    = acc_q;
  assign start_play_o  = start_q;
  assign play_id_o     = pid_q;
  assign status_o      = stat_q;
  assign queue_count_o = count_q;

endmodule

`default_nettype wire

// ===== hdl/dmq_checker.sv =====
// Port-level checks for the message queue top level, attached by bind.
// Depends on dmq_pkg and on the port names of the top level.
`default_nettype none

module dmq_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_stall_o,
  input wire logic                        out_valid_o,
  input wire logic                        out_stall_i,
  input wire logic                        accepted_o,
  input wire logic                        start_play_o,
  input wire logic [dmq_pkg::PlayIdW-1:0] play_id_o,
  input wire logic [dmq_pkg::StatusW-1:0] status_o,
  input wire logic [dmq_pkg::CountW-1:0]  queue_count_o
);

  import dmq_pkg::*;

  // A result held by the receiver keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
      $stable(queue_count_o) && $stable(play_id_o))
    else $error("stalled result changed");

  // An accepted item is never taken in the cycle right after another one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("item accepted during decide cycle");

  // A start is always reported with the started status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && start_play_o |-> status_o == STAT_STARTED)
    else $error("start without started status");

  // Only started, queued or current posts count as accepted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && accepted_o |->
      status_o == STAT_STARTED || status_o == STAT_QUEUED || status_o == STAT_CURRENT)
    else $error("accepted with a refusal status");

  // A queued post leaves at least one message waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STAT_QUEUED |-> queue_count_o != '0)
    else $error("queued status with empty queue");

endmodule

bind dedup_message_queue_with_holdoff_unit dmq_checker u_dmq_checker (.*);

`default_nettype wire
